// ===== design/cpm_pkg.sv =====
`timescale 1ns / 1ps

package cpm_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LENGTH_BITS    = 5;
   localparam int CHAR_BITS      = 8;
   localparam int START_BITS     = 16;
   localparam int CHARS_BITS     = 128;

   typedef logic [CHAR_BITS-1:0] char_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_CHARS_LOW      = 2'd1,
      REG_CHARS_HIGH     = 2'd2
   } csr_index_type;

   localparam char_type CHAR_DIGIT = 8'h44;  // 'D'
   localparam char_type CHAR_ALPHA = 8'h41;  // 'A'
   localparam char_type CHAR_ANY   = 8'h3F;  // '?'
   localparam char_type CASE_DELTA = 8'h20;

   function automatic logic is_digit(input char_type c);
      is_digit = c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_upper(input char_type c);
      is_upper = c inside {[8'h41:8'h5A]};
   endfunction

   function automatic logic is_lower(input char_type c);
      is_lower = c inside {[8'h61:8'h7A]};
   endfunction

   function automatic logic is_punct(input char_type c);
      is_punct = (c inside {[8'h21:8'h7E]}) && !is_digit(c) && !is_upper(c) && !is_lower(c);
   endfunction

   function automatic logic class_match(input char_type p, input char_type c);
      char_type folded;
      folded = is_upper(c) ? c + CASE_DELTA : c;
      if (p == CHAR_DIGIT) begin
         class_match = is_digit(c);
      end else if (p == CHAR_ALPHA) begin
         class_match = is_upper(c) || is_lower(c);
      end else if (p == CHAR_ANY) begin
         class_match = 1'b1;
      end else if (is_punct(p)) begin
         class_match = (p == c);
      end else if (is_lower(p)) begin
         class_match = (p == folded);
      end else begin
         class_match = 1'b0;
      end
   endfunction

endpackage

// ===== design/cpm_if.sv =====
`timescale 1ns / 1ps

interface cpm_req_if import cpm_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type text_char;
   logic     end_of_text;

   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface cpm_rsp_if import cpm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  match_found;
   logic [START_BITS-1:0] match_start;

   modport source (output valid, output match_found, output match_start, input ready);
   modport sink (input valid, input match_found, input match_start, output ready);
endinterface

interface cpm_csr_if import cpm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cpm_match_mask.sv =====
`timescale 1ns / 1ps

module cpm_match_mask
   import cpm_pkg::*;
#(
   parameter int PATTERN_MAX = 16
) (
   input  logic [CHARS_BITS-1:0]  pattern_chars,
   input  logic [LENGTH_BITS-1:0] pattern_length,
   input  char_type               text_char,
   output logic [PATTERN_MAX-1:0] mask
);

   // one class compare per pattern slot, slots past the length stay clear
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         mask[k] = (LENGTH_BITS'(k) < pattern_length) &&
                   class_match(pattern_chars[k*CHAR_BITS +: CHAR_BITS], text_char);
      end
   end

endmodule

// ===== design/char_class_pattern_matcher_top.sv =====
`timescale 1ns / 1ps

// Character-class pattern matcher.
// req_ch carries one text byte per item with an end_of_text flag; rsp_ch
// returns exactly one item per byte: match_found and match_start, the text
// position of the first byte of a window that matches the pattern and ends
// at this byte (0 when nothing matches). Overlapping windows are all found.
// csr_ch writes pattern_length (index 0) and the two 64-bit pattern
// character words (indexes 1 and 2); it is always ready and writes take
// effect for the next byte. Write it only while no item is in flight.
// The result is registered: valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver takes each result, set
// by the single shift-and update of the partial-match vector and position
// counter between the input handshake and the result register.
// When the receiver stalls, the result holds in its register and req_ch
// still takes a byte in any cycle where that register is being emptied.
// Reset clears the pattern, the partial-match vector, the position counter
// and the result valid. After a byte flagged end_of_text, the partial-match
// vector and position return to zero.

module char_class_pattern_matcher_top
   import cpm_pkg::*;
#(
   parameter int PATTERN_MAX   = 16,
   parameter int POSITION_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   cpm_req_if.sink   req_ch,
   cpm_rsp_if.source rsp_ch,
   cpm_csr_if.sink   csr_ch
);

   localparam int SUB_BITS = (POSITION_BITS > START_BITS) ? POSITION_BITS : START_BITS;

   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [CSR_DATA_BITS-1:0] chars_low_ff, chars_low_in;
   logic [CSR_DATA_BITS-1:0] chars_high_ff, chars_high_in;
   logic [PATTERN_MAX-1:0]   partial_ff, partial_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [START_BITS-1:0]    start_ff, start_in;

   logic [LENGTH_BITS-1:0] length_eff;
   logic [PATTERN_MAX-1:0] mask;
   logic [PATTERN_MAX-1:0] partial_next;
   logic                   found;
   logic [SUB_BITS-1:0]    start_full;
   logic                   accept;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      length_in     = length_ff;
      chars_low_in  = chars_low_ff;
      chars_high_in = chars_high_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_PATTERN_LENGTH: length_in     = csr_ch.data[LENGTH_BITS-1:0];
            REG_CHARS_LOW:      chars_low_in  = csr_ch.data;
            REG_CHARS_HIGH:     chars_high_in = csr_ch.data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   assign length_eff = (length_ff > LENGTH_BITS'(PATTERN_MAX)) ?
                       LENGTH_BITS'(PATTERN_MAX) : length_ff;

   cpm_match_mask #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_mask (
      .pattern_chars  ({chars_high_ff, chars_low_ff}),
      .pattern_length (length_eff),
      .text_char      (req_ch.text_char),
      .mask           (mask)
   );

   assign partial_next = PATTERN_MAX'({partial_ff, 1'b1}) & mask;

   always_comb begin
      found = 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         found = found | (partial_next[k] & (length_eff == LENGTH_BITS'(k + 1)));
      end
   end

   assign start_full = SUB_BITS'(position_ff) - SUB_BITS'(length_eff - LENGTH_BITS'(1));

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      partial_in   = partial_ff;
      position_in  = position_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         found_in     = found;
         start_in     = found ? start_full[START_BITS-1:0] : '0;
         if (req_ch.end_of_text) begin
            partial_in  = '0;
            position_in = '0;
         end else begin
            partial_in = partial_next;
            // saturate the position at its maximum
            if (position_ff != {POSITION_BITS{1'b1}}) begin
               position_in = position_ff + POSITION_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
         partial_ff    <= '0;
         position_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         length_ff     <= length_in;
         chars_low_ff  <= chars_low_in;
         chars_high_ff <= chars_high_in;
         partial_ff    <= partial_in;
         position_ff   <= position_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      found_ff <= found_in;
      start_ff <= start_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_found = found_ff;
   assign rsp_ch.match_start = start_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

import cpm_pkg::*;

localparam int PATTERN_SLOTS = 16;
localparam int POS_BITS      = 16;

typedef enum logic [2:0] {
   SYM_DIGIT,
   SYM_ALPHA,
   SYM_ANY,
   SYM_EXACT,
   SYM_FOLD,
   SYM_NEVER
} symbol_kind_type;

typedef struct packed {
   logic                  found;
   logic [START_BITS-1:0] start;
} match_result_type;

function automatic bit digit_byte(char_type c);
   return c >= 8'h30 && c <= 8'h39;
endfunction

function automatic bit upper_byte(char_type c);
   return c >= 8'h41 && c <= 8'h5A;
endfunction

function automatic bit lower_byte(char_type c);
   return c >= 8'h61 && c <= 8'h7A;
endfunction

function automatic symbol_kind_type symbol_kind(char_type p);
   if (p == CHAR_DIGIT) return SYM_DIGIT;
   if (p == CHAR_ALPHA) return SYM_ALPHA;
   if (p == CHAR_ANY) return SYM_ANY;
   if (lower_byte(p)) return SYM_FOLD;
   if (p >= 8'h21 && p <= 8'h7E && !digit_byte(p) && !upper_byte(p)) return SYM_EXACT;
   return SYM_NEVER;
endfunction

function automatic bit pattern_accepts(char_type p, char_type c);
   char_type folded;
   folded = upper_byte(c) ? c + CASE_DELTA : c;
   case (symbol_kind(p))
      SYM_DIGIT: return digit_byte(c);
      SYM_ALPHA: return upper_byte(c) || lower_byte(c);
      SYM_ANY:   return 1'b1;
      SYM_EXACT: return p == c;
      SYM_FOLD:  return p == folded;
      default:   return 1'b0;
   endcase
endfunction

class match_scoreboard;
   logic [LENGTH_BITS-1:0]   length_reg;
   logic [CHARS_BITS-1:0]    chars_reg;
   logic [PATTERN_SLOTS-1:0] partial_bits;
   logic [POS_BITS-1:0]      position;
   match_result_type         expected[$];
   int                       errors;
   int                       results_seen;

   function new();
      length_reg   = '0;
      chars_reg    = '0;
      partial_bits = '0;
      position     = '0;
      errors       = 0;
      results_seen = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_PATTERN_LENGTH: length_reg = value[LENGTH_BITS-1:0];
         REG_CHARS_LOW:      chars_reg[63:0] = value;
         REG_CHARS_HIGH:     chars_reg[127:64] = value;
         default: ;
      endcase
   endfunction

   function void note_char(char_type c, logic last);
      int                       len;
      logic [PATTERN_SLOTS-1:0] hits;
      match_result_type         r;
      len = (length_reg > PATTERN_SLOTS) ? PATTERN_SLOTS : int'(length_reg);
      hits = '0;
      for (int k = 0; k < len; k++) begin
         hits[k] = pattern_accepts(chars_reg[k*CHAR_BITS +: CHAR_BITS], c);
      end
      partial_bits = {partial_bits[PATTERN_SLOTS-2:0], 1'b1} & hits;
      r = '0;
      if (len > 0 && partial_bits[len-1]) begin
         r.found = 1'b1;
         r.start = START_BITS'(position - POS_BITS'(len - 1));
      end
      expected = {expected, r};
      if (last) begin
         partial_bits = '0;
         position     = '0;
      end else if (position != '1) begin
         position = position + 1'b1;
      end
   endfunction

   task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   task check_result(logic found, logic [START_BITS-1:0] start);
      match_result_type want;
      results_seen++;
      if (expected.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
         want = expected.pop_front();
         if (found !== want.found) begin
            report_mismatch($sformatf("result %0d match_found %b, expected %b",
                                      results_seen, found, want.found));
         end
         if (start !== want.start) begin
            report_mismatch($sformatf("result %0d match_start %0d, expected %0d",
                                      results_seen, start, want.start));
         end
      end
   endtask
endclass

module testbench;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int LONG_TEXT      = 300;

   logic clock = 1'b0;
   logic reset;

   cpm_req_if req_ch ();
   cpm_rsp_if rsp_ch ();
   cpm_csr_if csr_ch ();

   match_scoreboard sb = new();

   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   int                    hold_asked     = 0;
   int                    stall_cycles   = 0;
   int                    cur_len        = 0;
   logic [CHARS_BITS-1:0] cur_chars      = '0;

   char_class_pattern_matcher_top #(
      .PATTERN_MAX  (PATTERN_SLOTS),
      .POSITION_BITS(POS_BITS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #4 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off when one is asked for.
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.match_found, rsp_ch.match_start);
         end
         if (req_ch.valid && req_ch.ready) sb.note_char(req_ch.text_char, req_ch.end_of_text);
         if (csr_ch.valid && csr_ch.ready) sb.write_reg(csr_ch.index, csr_ch.data);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("testbench: FAIL");
      $finish;
   end

   function automatic char_type sample_for(char_type p);
      case (symbol_kind(p))
         SYM_DIGIT: return 8'h30 + char_type'($urandom_range(9));
         SYM_ALPHA: return ($urandom_range(1) ? 8'h41 : 8'h61) + char_type'($urandom_range(25));
         SYM_EXACT: return p;
         SYM_FOLD:  return $urandom_range(1) ? p - CASE_DELTA : p;
         default:   return char_type'($urandom_range(255));
      endcase
   endfunction

   function automatic char_type random_symbol();
      char_type p;
      case ($urandom_range(9))
         0, 1: p = CHAR_DIGIT;
         2, 3: p = CHAR_ALPHA;
         4:    p = CHAR_ANY;
         5, 6: begin
            p = char_type'($urandom_range(8'h7E, 8'h21));
            while (symbol_kind(p) != SYM_EXACT) p = char_type'($urandom_range(8'h7E, 8'h21));
         end
         7, 8: p = 8'h61 + char_type'($urandom_range(25));
         default: p = char_type'($urandom_range(255));
      endcase
      return p;
   endfunction

   task automatic send_char(char_type c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_char   <= c;
      req_ch.end_of_text <= last;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected.size() != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
   endtask

   task automatic load_pattern(logic [CSR_DATA_BITS-1:0] len_word,
                               logic [CHARS_BITS-1:0] chars, bit poke_unused);
      put_reg(REG_PATTERN_LENGTH, len_word);
      put_reg(REG_CHARS_LOW, chars[63:0]);
      put_reg(REG_CHARS_HIGH, chars[127:64]);
      if (poke_unused) put_reg(REG_UNUSED, {$urandom(), $urandom()});
      csr_ch.valid <= 1'b0;
      cur_chars = chars;
      cur_len = (len_word[LENGTH_BITS-1:0] > PATTERN_SLOTS) ? PATTERN_SLOTS
                                                           : int'(len_word[LENGTH_BITS-1:0]);
   endtask

   task automatic stream_text(int count);
      int       sent;
      char_type c;
      sent = 0;
      while (sent < count) begin
         if (cur_len > 0 && $urandom_range(99) < 60) begin
            // well-formed window, now and then broken by a stray byte
            for (int k = 0; k < cur_len && sent < count; k++) begin
               c = ($urandom_range(99) < 8) ? char_type'($urandom_range(255))
                                           : sample_for(cur_chars[k*CHAR_BITS +: CHAR_BITS]);
               send_char(c, $urandom_range(99) < 3);
               sent++;
            end
         end else begin
            send_char(char_type'($urandom_range(255)), $urandom_range(99) < 3);
            sent++;
         end
      end
   endtask

   task automatic run_block(int blk);
      logic [CSR_DATA_BITS-1:0] len_word;
      logic [CHARS_BITS-1:0]    chars;
      for (int k = 0; k < PATTERN_SLOTS; k++) chars[k*CHAR_BITS +: CHAR_BITS] = random_symbol();
      len_word = CSR_DATA_BITS'($urandom_range(8, 1));
      case (blk)
         1: len_word = 64'd16;
         3: len_word = {$urandom(), 27'($urandom()), 5'd31};
         4: len_word = 64'd0;
         6: chars = {$urandom(), $urandom(), $urandom(), $urandom()};
         7: begin
            len_word = 64'd16;
            chars    = '1;
         end
         9: begin
            len_word = 64'd8;
            chars    = '0;
         end
         default: ;
      endcase
      wait_for_results();
      case (blk % 4)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 71;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 71;
         end
         default: begin
            send_idle_pct  = 34;
            recv_stall_pct = 34;
         end
      endcase
      load_pattern(len_word, chars, blk == 5);
      // receiver holds off while the sender keeps offering, so the block backs up
      if (blk == 0) hold_asked = hold_asked + 1;
      if (blk == 5) begin
         stream_text(45);
         wait_for_results();
         stream_text(45);
      end else begin
         stream_text(90);
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.text_char   <= '0;
      req_ch.end_of_text <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero length after reset: never a match
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);

      // letter, digit, any, folded 'x', exact '#'
      wait_for_results();
      load_pattern(64'd5, {64'h0, 64'h0000_0023_783F_4441}, 1'b0);
      send_char(8'h7A, 1'b0);
      send_char(8'h39, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h58, 1'b0);
      send_char(8'h23, 1'b1);

      // length above the maximum clamps; overlapping windows of any byte
      wait_for_results();
      load_pattern(64'd31, {16{CHAR_ANY}}, 1'b0);
      for (int i = 0; i < 17; i++) send_char((i % 2) ? 8'hFF : 8'h00, i == 16);

      // uppercase non-class and high bytes in the pattern never match
      wait_for_results();
      load_pattern(64'd2, {112'h0, 8'h80, 8'h51}, 1'b0);
      send_char(8'h51, 1'b0);
      send_char(8'h80, 1'b1);

      for (int blk = 0; blk < 11; blk++) run_block(blk);

      // one long unbroken text keeps the position counting up
      wait_for_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_pattern(64'd2, {112'h0, CHAR_ANY, CHAR_DIGIT}, 1'b0);
      for (int i = 0; i < LONG_TEXT; i++) begin
         send_char(($urandom_range(3) != 0) ? sample_for(CHAR_DIGIT)
                                            : char_type'($urandom_range(255)), 1'b0);
      end
      send_char(sample_for(CHAR_DIGIT), 1'b1);
      stream_text(16);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

// ===== char_class_pattern_matcher_top.f =====
design/cpm_pkg.sv
design/cpm_if.sv
design/cpm_match_mask.sv
design/char_class_pattern_matcher_top.sv
bench/testbench.sv
